// ----- rtl/pee_pkg.sv -----
// Shared types, widths and codes for the pairwise exclusion energy block.
// No dependencies; imported by pairwise_exclusion_energy.
package pee_pkg;

  localparam int MAX_TARGETS_DEF = 32;

  localparam int COORD_W     = 32;
  localparam int SLOT_W      = 20;
  localparam int GRAD_W      = 32;
  localparam int GACC_W      = 38;   // holds 63 terms of 32 bits
  localparam int ENERGY_W    = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 136;
  localparam int DIV_CNT_W   = 6;
  localparam int E_QBITS     = 48;
  localparam int G_QBITS     = 32;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
  localparam logic [GRAD_W-1:0]   GRAD_MAX   = 32'h7FFF_FFFF;
  localparam logic [GRAD_W-1:0]   GRAD_MIN   = 32'h8000_0000;
  localparam logic [31:0]         GSQ_RESET  = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_STEP_SQ = 2'd0,
    CFG_GRAD_EN      = 2'd1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_I, S_LAT_I, S_RD_J, S_LAT_J,
    S_M_SX, S_M_SY, S_M_PX, S_M_PY, S_M_Q0, S_M_Q1, S_M_Q2,
    S_E_START, S_DIV, S_DIV_DONE, S_GX_START, S_GY_START,
    S_NEXT_J, S_WR_I, S_OUT_RD, S_OUT_LAT, S_OUT_WAIT
  } pee_state_e;

  typedef enum logic [1:0] {
    DIV_ENERGY,
    DIV_GX,
    DIV_GY
  } div_kind_e;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } tgt_ent_t;

  typedef struct packed {
    logic              pres;
    logic [GRAD_W-1:0] gy;
    logic [GRAD_W-1:0] gx;
  } grad_ent_t;

  typedef struct packed {
    logic              flag;
    logic [GRAD_W-1:0] val;
  } grad_res_t;

endpackage

// ----- rtl/pairwise_exclusion_energy.sv -----
// Pairwise exclusion energy: target store, pair sequencer, shared multiplier
// and shared restoring divider. Depends on pee_pkg.
//
// Targets of a frame stream in one per transfer and are written to a target
// memory (x, y, slot); an x of zero marks an absent target. The transfer
// carrying tlast closes the frame: the block then walks every ordered pair of
// distinct present targets, adds G/d^2 to the running energy (unsigned Q32.16,
// saturating) and, when gradients are enabled, sums -4*d*G/d^4 per target into
// a gradient memory. Afterwards it sends one result per stored target in load
// order, each carrying the frame's final energy and sticky overflow flag.
// s_axis_tuser set clears energy and overflow before its frame.
// The 48-step energy division and, with gradients on, two 32-step gradient
// divisions of each present pair share the single divider; a gradient
// division is skipped when its term is zero, and any division when it
// saturates early. Each target also needs a read and a gradient write, each
// partner skipped as itself or absent a read, and each result a read before
// its handshake. New targets are taken only while the block is idle.
module pairwise_exclusion_energy
  import pee_pkg::*;
#(
  parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // target input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pos_x, pos_y, slot_index
  input  logic                   s_axis_tlast,   // last_in_frame
  input  logic                   s_axis_tuser,   // first_frame
  // results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_slot, grad_x, grad_y,
                                                 // energy_total, overflow
  output logic                   m_axis_tlast,   // last_of_frame
  output logic                   m_axis_tuser,   // present
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int IDX_W = $clog2(MAX_TARGETS);
  localparam int CNT_W = $clog2(MAX_TARGETS + 1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  pee_state_e state_q, state_d;

  logic [31:0]         gsq_q;       // grid step squared
  logic                gen_q;       // gradient enable
  logic [CNT_W-1:0]    cnt_q;       // targets stored this frame
  logic [CNT_W-1:0]    n_q;         // targets in the frame being processed
  logic [CNT_W-1:0]    i_q, j_q;
  logic [ENERGY_W-1:0] energy_q;
  logic                ovf_q;
  logic                m_valid_q;

  // pair datapath
  logic [COORD_W-1:0]  xi_q, yi_q;
  logic                pres_q;
  logic [32:0]         adx_q, ady_q;
  logic                xneg_q, yneg_q;
  logic [65:0]         prod_q;
  logic [63:0]         sx_q, d_q;
  logic [64:0]         px_q, py_q;
  logic [127:0]        dd_q;
  logic [GACC_W-1:0]   gx_q, gy_q;

  // divider
  logic [127:0]        rem_q, den_q;
  logic [E_QBITS-1:0]  low_q, quo_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  div_kind_e           kind_q;

  // output payload
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_last_q, out_pres_q;

  // memories
  tgt_ent_t  tgt_mem [MAX_TARGETS];
  grad_ent_t grad_mem [MAX_TARGETS];
  tgt_ent_t  tgt_rd_q;
  grad_ent_t grad_rd_q;

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  // Gradient term from a quotient; pos means own coordinate above partner's.
  function automatic grad_res_t grad_fix(input logic sat, input logic [31:0] q,
                                         input logic pos);
    grad_res_t r;
    if (sat) begin
      r.flag = 1'b1;
      r.val  = pos ? GRAD_MIN : GRAD_MAX;
    end else if (q[31]) begin
      r.val  = pos ? GRAD_MIN : GRAD_MAX;
      r.flag = pos ? (q[30:0] != '0) : 1'b1;
    end else begin
      r.flag = 1'b0;
      r.val  = pos ? (32'd0 - q) : q;
    end
    return r;
  endfunction

  function automatic grad_res_t clamp_g(input logic [GACC_W-1:0] v);
    grad_res_t r;
    if (v[GACC_W-1:GRAD_W-1] == {(GACC_W-GRAD_W+1){v[GACC_W-1]}}) begin
      r.flag = 1'b0;
      r.val  = v[GRAD_W-1:0];
    end else begin
      r.flag = 1'b1;
      r.val  = v[GACC_W-1] ? GRAD_MIN : GRAD_MAX;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshakes and input unpack
  // ---------------------------------------------------------------------------
  tgt_ent_t in_ent;
  logic     in_xfer, out_xfer, room;

  assign in_ent.x    = s_axis_tdata[31:0];
  assign in_ent.y    = s_axis_tdata[63:32];
  assign in_ent.slot = s_axis_tdata[83:64];

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_valid_q && m_axis_tready;
  assign room          = (cnt_q < CNT_W'(MAX_TARGETS));

  logic [CNT_W-1:0] i_inc, j_inc;
  logic             i_last, j_last;
  assign i_inc  = i_q + CNT_W'(1);
  assign j_inc  = j_q + CNT_W'(1);
  assign i_last = (i_inc == n_q);
  assign j_last = (j_inc == n_q);

  // ---------------------------------------------------------------------------
  // Shared combinational datapath
  // ---------------------------------------------------------------------------
  logic [32:0]  mul_a, mul_b;
  logic [32:0]  dx, dy;
  logic [64:0]  d_sum;
  logic         e_pre_sat, gx_pre_sat, gy_pre_sat;
  logic [127:0] gx_rem_init, gy_rem_init;
  logic [128:0] div_rem2, div_diff;
  logic         div_ge;
  logic         gsat, gpos, g_apply;
  grad_res_t    gres, cgx, cgy;
  logic         e_add_en;
  logic [ENERGY_W-1:0] e_term;
  logic [ENERGY_W:0]   e_sum;
  logic         ovf_set;

  assign dx = {xi_q[31], xi_q} - {tgt_rd_q.x[31], tgt_rd_q.x};
  assign dy = {yi_q[31], yi_q} - {tgt_rd_q.y[31], tgt_rd_q.y};

  assign d_sum       = {1'b0, sx_q} + {1'b0, prod_q[63:0]};
  assign e_pre_sat   = (d_q == '0) || ({48'd0, gsq_q[31:16]} >= d_q);
  assign gx_rem_init = {45'd0, px_q, 18'd0};
  assign gy_rem_init = {45'd0, py_q, 18'd0};
  assign gx_pre_sat  = (gx_rem_init >= dd_q);
  assign gy_pre_sat  = (gy_rem_init >= dd_q);

  assign div_rem2 = {rem_q, low_q[E_QBITS-1]};
  assign div_diff = div_rem2 - {1'b0, den_q};
  assign div_ge   = (div_rem2 >= {1'b0, den_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_M_SX: begin mul_a = adx_q; mul_b = adx_q; end
      S_M_SY: begin mul_a = ady_q; mul_b = ady_q; end
      S_M_PX: begin mul_a = adx_q; mul_b = {1'b0, gsq_q}; end
      S_M_PY: begin mul_a = ady_q; mul_b = {1'b0, gsq_q}; end
      S_M_Q0: begin mul_a = {1'b0, d_q[31:0]};  mul_b = {1'b0, d_q[31:0]}; end
      S_M_Q1: begin mul_a = {1'b0, d_q[31:0]};  mul_b = {1'b0, d_q[63:32]}; end
      S_M_Q2: begin mul_a = {1'b0, d_q[63:32]}; mul_b = {1'b0, d_q[63:32]}; end
      default: ;
    endcase
  end

  // gradient term select: early saturation in the start states, else quotient
  always_comb begin
    gsat = 1'b0;
    gpos = !xneg_q;
    if (state_q == S_GX_START) begin
      gsat = 1'b1;
    end else if (state_q == S_GY_START) begin
      gsat = 1'b1;
      gpos = !yneg_q;
    end else if (kind_q == DIV_GY) begin
      gpos = !yneg_q;
    end
  end

  assign gres = grad_fix(gsat, quo_q[G_QBITS-1:0], gpos);
  assign cgx  = clamp_g(gx_q);
  assign cgy  = clamp_g(gy_q);

  assign g_apply = (state_q == S_GX_START && adx_q != '0 && gx_pre_sat)
                || (state_q == S_GY_START && ady_q != '0 && gy_pre_sat)
                || (state_q == S_DIV_DONE && kind_q != DIV_ENERGY);

  always_comb begin
    e_add_en = 1'b0;
    e_term   = quo_q;
    if (state_q == S_E_START && e_pre_sat) begin
      e_add_en = 1'b1;
      e_term   = ENERGY_MAX;
    end else if (state_q == S_DIV_DONE && kind_q == DIV_ENERGY) begin
      e_add_en = 1'b1;
    end
  end

  assign e_sum = {1'b0, energy_q} + {1'b0, e_term};

  assign ovf_set = (state_q == S_M_PX && d_sum[64])
                || (state_q == S_E_START && e_pre_sat)
                || (e_add_en && e_sum[ENERGY_W])
                || (g_apply && gres.flag)
                || (state_q == S_WR_I && (cgx.flag || cgy.flag));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_xfer && s_axis_tlast) state_d = S_RD_I;
      S_RD_I:     state_d = S_LAT_I;
      S_LAT_I:    state_d = (tgt_rd_q.x == '0) ? S_WR_I : S_RD_J;
      S_RD_J:     state_d = S_LAT_J;
      S_LAT_J:    state_d = (j_q == i_q || tgt_rd_q.x == '0) ? S_NEXT_J : S_M_SX;
      S_M_SX:     state_d = S_M_SY;
      S_M_SY:     state_d = S_M_PX;
      S_M_PX:     state_d = S_M_PY;
      S_M_PY:     state_d = S_M_Q0;
      S_M_Q0:     state_d = S_M_Q1;
      S_M_Q1:     state_d = S_M_Q2;
      S_M_Q2:     state_d = S_E_START;
      S_E_START: begin
        if (!e_pre_sat)  state_d = S_DIV;
        else if (gen_q)  state_d = S_GX_START;
        else             state_d = S_NEXT_J;
      end
      S_DIV:      if (div_cnt_q == DIV_CNT_W'(1)) state_d = S_DIV_DONE;
      S_DIV_DONE: begin
        unique case (kind_q)
          DIV_ENERGY: state_d = gen_q ? S_GX_START : S_NEXT_J;
          DIV_GX:     state_d = S_GY_START;
          DIV_GY:     state_d = S_NEXT_J;
          default:    state_d = S_NEXT_J;
        endcase
      end
      S_GX_START: state_d = (adx_q == '0 || gx_pre_sat) ? S_GY_START : S_DIV;
      S_GY_START: state_d = (ady_q == '0 || gy_pre_sat) ? S_NEXT_J : S_DIV;
      S_NEXT_J:   state_d = j_last ? S_WR_I : S_RD_J;
      S_WR_I:     state_d = i_last ? S_OUT_RD : S_RD_I;
      S_OUT_RD:   state_d = S_OUT_LAT;
      S_OUT_LAT:  state_d = S_OUT_WAIT;
      S_OUT_WAIT: if (out_xfer) state_d = i_last ? S_IDLE : S_OUT_RD;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsq_q     <= GSQ_RESET;
      gen_q     <= 1'b1;
      cnt_q     <= '0;
      n_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      energy_q  <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_GRID_STEP_SQ: gsq_q <= cfg_data_i;
          CFG_GRAD_EN:      gen_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (ovf_set) ovf_q <= 1'b1;
      if (e_add_en) energy_q <= e_sum[ENERGY_W] ? ENERGY_MAX : e_sum[ENERGY_W-1:0];

      if (in_xfer) begin
        if (s_axis_tuser) begin
          energy_q <= '0;
          ovf_q    <= 1'b0;
        end
        if (room) cnt_q <= cnt_q + CNT_W'(1);
        if (s_axis_tlast) begin
          n_q <= room ? cnt_q + CNT_W'(1) : cnt_q;
          i_q <= '0;
        end
      end

      if (state_q == S_LAT_I)  j_q <= '0;
      if (state_q == S_NEXT_J) j_q <= j_inc;
      if (state_q == S_WR_I)   i_q <= i_last ? '0 : i_inc;
      if (state_q == S_OUT_LAT) m_valid_q <= 1'b1;
      if (out_xfer) begin
        m_valid_q <= 1'b0;
        i_q       <= i_inc;
        if (i_last) cnt_q <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      S_LAT_I: begin
        xi_q   <= tgt_rd_q.x;
        yi_q   <= tgt_rd_q.y;
        pres_q <= (tgt_rd_q.x != '0);
        gx_q   <= '0;
        gy_q   <= '0;
      end
      S_LAT_J: begin
        adx_q  <= dx[32] ? (33'd0 - dx) : dx;
        ady_q  <= dy[32] ? (33'd0 - dy) : dy;
        xneg_q <= dx[32];
        yneg_q <= dy[32];
      end
      S_M_SY: sx_q <= prod_q[63:0];
      S_M_PX: d_q  <= d_sum[64] ? '1 : d_sum[63:0];
      S_M_PY: px_q <= prod_q[64:0];
      S_M_Q0: py_q <= prod_q[64:0];
      S_M_Q1: dd_q <= {64'd0, prod_q[63:0]};
      S_M_Q2: dd_q <= dd_q + {31'd0, prod_q[63:0], 33'd0};
      S_E_START: begin
        dd_q      <= dd_q + {prod_q[63:0], 64'd0};
        rem_q     <= {112'd0, gsq_q[31:16]};
        den_q     <= {64'd0, d_q};
        low_q     <= {gsq_q[15:0], 32'd0};
        quo_q     <= '0;
        div_cnt_q <= DIV_CNT_W'(E_QBITS);
        kind_q    <= DIV_ENERGY;
      end
      S_GX_START: begin
        if (adx_q != '0 && gx_pre_sat) gx_q <= gx_q + {{(GACC_W-GRAD_W){gres.val[31]}}, gres.val};
        rem_q     <= gx_rem_init;
        den_q     <= dd_q;
        low_q     <= '0;
        quo_q     <= '0;
        div_cnt_q <= DIV_CNT_W'(G_QBITS);
        kind_q    <= DIV_GX;
      end
      S_GY_START: begin
        if (ady_q != '0 && gy_pre_sat) gy_q <= gy_q + {{(GACC_W-GRAD_W){gres.val[31]}}, gres.val};
        rem_q     <= gy_rem_init;
        den_q     <= dd_q;
        low_q     <= '0;
        quo_q     <= '0;
        div_cnt_q <= DIV_CNT_W'(G_QBITS);
        kind_q    <= DIV_GY;
      end
      S_DIV: begin
        rem_q     <= div_ge ? div_diff[127:0] : div_rem2[127:0];
        quo_q     <= {quo_q[E_QBITS-2:0], div_ge};
        low_q     <= {low_q[E_QBITS-2:0], 1'b0};
        div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
      end
      S_DIV_DONE: begin
        if (kind_q == DIV_GX) gx_q <= gx_q + {{(GACC_W-GRAD_W){gres.val[31]}}, gres.val};
        if (kind_q == DIV_GY) gy_q <= gy_q + {{(GACC_W-GRAD_W){gres.val[31]}}, gres.val};
      end
      S_OUT_LAT: begin
        out_data_q <= {3'd0, ovf_q, energy_q, grad_rd_q.gy, grad_rd_q.gx, tgt_rd_q.slot};
        out_last_q <= i_last;
        out_pres_q <= grad_rd_q.pres;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memories: target store and per-target gradients
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] tgt_raddr;
  assign tgt_raddr = (state_q == S_RD_J) ? j_q[IDX_W-1:0] : i_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (in_xfer && room) tgt_mem[cnt_q[IDX_W-1:0]] <= in_ent;
    tgt_rd_q <= tgt_mem[tgt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WR_I) begin
      grad_mem[i_q[IDX_W-1:0]] <= '{pres: pres_q, gy: cgy.val, gx: cgx.val};
    end
    grad_rd_q <= grad_mem[i_q[IDX_W-1:0]];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_pres_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> state_q == S_OUT_WAIT)
    else $error("result shown outside output wait");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_TARGETS))
    else $error("target count beyond store depth");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> div_cnt_q != '0)
    else $error("divider running with zero step count");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
      (cnt_q == '0 && state_q == S_IDLE))
    else $error("store not released after last result");

  a_i_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR_I |-> i_q < n_q)
    else $error("target index beyond frame size");

endmodule
